@@ sv/rtp_pkg.sv @@
// rtp_pkg: shared types, character constants and digit decode for the
// radix integer text parser. No dependencies.
`timescale 1ns / 1ps

package rtp_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned RadixW  = 6;
    localparam int unsigned ValueW  = 64;
    localparam int unsigned CountW  = 8;
    localparam int unsigned AddrW   = 3;
    localparam int unsigned DataW   = 32;
    localparam int unsigned TdataInW  = 8;
    localparam int unsigned TdataOutW = 72;

    localparam logic [ByteW-1:0] ChZero    = 8'h30;  // '0'
    localparam logic [ByteW-1:0] ChNine    = 8'h39;  // '9'
    localparam logic [ByteW-1:0] ChUpperA  = 8'h41;  // 'A'
    localparam logic [ByteW-1:0] ChUpperZ  = 8'h5A;  // 'Z'
    localparam logic [ByteW-1:0] ChLowerA  = 8'h61;  // 'a'
    localparam logic [ByteW-1:0] ChLowerZ  = 8'h7A;  // 'z'
    localparam logic [ByteW-1:0] ChMinus   = 8'h2D;  // '-'
    localparam logic [ByteW-1:0] ChTab     = 8'h09;  // '\t'
    localparam logic [ByteW-1:0] ChCr      = 8'h0D;  // '\r'
    localparam logic [ByteW-1:0] ChSpace   = 8'h20;  // ' '
    localparam logic [ByteW-1:0] UpperBase = 8'h37;  // 'A' - 10
    localparam logic [ByteW-1:0] LowerBase = 8'h57;  // 'a' - 10

    localparam logic [CountW-1:0] CountMax = '1;

    localparam logic [RadixW-1:0] RadixReset  = 6'd10;
    localparam logic              SignedReset = 1'b1;

    // register word indexes (paddr[2])
    localparam logic RegRadix  = 1'b0;
    localparam logic RegSigned = 1'b1;

    localparam logic StatusOk       = 1'b0;
    localparam logic StatusNoDigits = 1'b1;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_SIGN   = 3'b010,
        PH_DIGITS = 3'b100
    } phase_t;

    typedef struct packed {
        logic             valid;
        logic [RadixW-1:0] value;
    } digit_t;

    function automatic digit_t decode_digit(input logic [ByteW-1:0] b);
        digit_t d;
        logic [ByteW-1:0] diff;
        d    = '0;
        diff = '0;
        if (b >= ChZero && b <= ChNine) begin
            diff = b - ChZero;
            d.valid = 1'b1;
        end else if (b >= ChUpperA && b <= ChUpperZ) begin
            diff = b - UpperBase;
            d.valid = 1'b1;
        end else if (b >= ChLowerA && b <= ChLowerZ) begin
            diff = b - LowerBase;
            d.valid = 1'b1;
        end
        d.value = diff[RadixW-1:0];
        return d;
    endfunction

    function automatic logic is_space(input logic [ByteW-1:0] b);
        return (b >= ChTab && b <= ChCr) || (b == ChSpace);
    endfunction

endpackage

@@ sv/radix_integer_text_parser.sv @@
// A result appears on m_* in the cycle after the transfer of the byte
// (or end-of-text marker) that ends the number; digits produce no result.
// Throughput: one input transfer per cycle; s_tready stays high while the
// output register is empty or is being drained in the same cycle.
// The per-byte loop is one 64x6 multiply-add into the accumulator register.
// Reset (synchronous, aresetn low): phase to whitespace skipping, radix 10,
// signed mode on, output register empty.
`timescale 1ns / 1ps

module radix_integer_text_parser
    import rtp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // text input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TdataInW-1:0]   s_tdata,   // [7:0] text_byte
    input  logic                  s_tlast,   // end_of_text

    // parsed numbers
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TdataOutW-1:0]  m_tdata,   // [63:0] number_value, [71:64] digit_count
    output logic                  m_tuser,   // parse_status

    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [AddrW-1:0]      paddr,
    input  logic [DataW-1:0]      pwdata,
    output logic [DataW-1:0]      prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Address bits [1:0] are ignored.
    // ------------------------------------------------------------------
    logic [RadixW-1:0] radix_reg;
    logic              signed_reg;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg  <= RadixReset;
            signed_reg <= SignedReset;
        end else if (cfg_write) begin
            if (paddr[2] == RegRadix) begin
                radix_reg <= pwdata[RadixW-1:0];
            end else begin
                signed_reg <= pwdata[0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == RegRadix) begin
            prdata[RadixW-1:0] = radix_reg;
        end else begin
            prdata[0] = signed_reg;
        end
    end

    // ------------------------------------------------------------------
    // Parse state. Accumulator and count are kept at zero outside the
    // digit phase, so a first digit just loads them.
    // ------------------------------------------------------------------
    phase_t             phase_reg, phase_next;
    logic               minus_reg, minus_next;
    logic [ValueW-1:0]  acc_reg,   acc_next;
    logic [CountW-1:0]  cnt_reg,   cnt_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [ValueW-1:0]  out_value_reg, out_value_next;
    logic [CountW-1:0]  out_count_reg, out_count_next;
    logic               out_status_reg, out_status_next;

    logic               accept;
    logic [ByteW-1:0]   text_byte;
    logic               eot;
    digit_t             dig;
    logic               is_digit;
    logic               minus_opens;
    logic               emit;
    logic [ValueW-1:0]  acc_step;
    logic [CountW-1:0]  cnt_step;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign text_byte = s_tdata[ByteW-1:0];
    assign eot       = s_tlast;

    assign dig         = decode_digit(text_byte);
    assign is_digit    = dig.valid && (dig.value < radix_reg);
    assign minus_opens = signed_reg && (text_byte == ChMinus);

    // one multiply-add per byte, wrapping at 64 bits
    assign acc_step = (acc_reg * ValueW'(radix_reg)) + ValueW'(dig.value);
    assign cnt_step = (cnt_reg == CountMax) ? cnt_reg : cnt_reg + CountW'(1);

    always_comb begin
        phase_next      = phase_reg;
        minus_next      = minus_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        emit            = 1'b0;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;

        if (accept) begin
            unique case (phase_reg)
                PH_DIGITS, PH_SIGN: begin
                    if (!eot && is_digit) begin
                        acc_next   = acc_step;
                        cnt_next   = cnt_step;
                        phase_next = PH_DIGITS;
                    end else begin
                        emit = 1'b1;
                        if (phase_reg == PH_DIGITS) begin
                            out_value_next  = minus_reg ? (ValueW'(0) - acc_reg) : acc_reg;
                            out_count_next  = cnt_reg;
                            out_status_next = StatusOk;
                        end else begin
                            // lone minus
                            out_value_next  = '0;
                            out_count_next  = '0;
                            out_status_next = StatusNoDigits;
                        end
                        acc_next = '0;
                        cnt_next = '0;
                        // a minus right after a number opens the next one
                        if (!eot && minus_opens) begin
                            phase_next = PH_SIGN;
                            minus_next = 1'b1;
                        end else begin
                            phase_next = PH_SKIP;
                            minus_next = 1'b0;
                        end
                    end
                end
                default: begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    minus_next = 1'b0;
                    phase_next = PH_SKIP;
                    if (eot || is_space(text_byte)) begin
                        phase_next = PH_SKIP;
                    end else if (is_digit) begin
                        acc_next   = ValueW'(dig.value);
                        cnt_next   = CountW'(1);
                        phase_next = PH_DIGITS;
                    end else if (minus_opens) begin
                        phase_next = PH_SIGN;
                        minus_next = 1'b1;
                    end else begin
                        // stray byte
                        emit            = 1'b1;
                        out_value_next  = '0;
                        out_count_next  = '0;
                        out_status_next = StatusNoDigits;
                    end
                end
            endcase
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SKIP;
            minus_reg     <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            minus_reg     <= minus_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_value_reg};
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    // no-digits results carry zero value and count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == StatusNoDigits) |-> (m_tdata == '0))
        else $error("no-digits result with nonzero payload");

    // a parsed number always has at least one digit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == StatusOk) |-> (m_tdata[TdataOutW-1:ValueW] != '0))
        else $error("parsed number with zero digit count");

    // outside the digit phase the accumulator and count stay cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_DIGITS) |-> (acc_reg == '0 && cnt_reg == '0))
        else $error("accumulator not cleared outside digit phase");

    // minus flag only set in sign or digit phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SKIP) |-> !minus_reg)
        else $error("minus flag set while skipping");

    // an accepted digit always lands in the digit phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !eot && is_digit) |=> (phase_reg == PH_DIGITS))
        else $error("digit did not enter digit phase");
`endif

endmodule
